>>> sv/sprite_quad_vertex_setup_defines.svh
// Assertion macros for the sprite quad vertex setup checker.
`ifndef SPRITE_QUAD_VERTEX_SETUP_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_SETUP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SQVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqvs assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SQVS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqvs assertion failed");

`endif

>>> sv/sqvs_pkg.sv
package sqvs_pkg;

  localparam int VERTEX_COUNT = 4;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 14;
  localparam logic [CFG_AW-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [13:0] SCREEN_WIDTH_RST  = 14'd1280;
  localparam logic [13:0] SCREEN_HEIGHT_RST = 14'd720;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  localparam int DIV_NW = 36;
  localparam int DIV_DW = 19;
  localparam int DIV_CW = 6;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0] size_x;
    logic [15:0] size_y;
    logic [15:0] cut_x;
    logic [15:0] cut_y;
    logic [15:0] cut_w;
    logic [15:0] cut_h;
    logic [15:0] angle;
    logic [13:0] tex_width;
    logic [13:0] tex_height;
    logic [31:0] color;
  } sqvs_in_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic               last;
  } sqvs_out_t;

  // Sprite after the front end: sine/cosine resolved, centre formed.
  typedef struct packed {
    logic signed [15:0] cs;
    logic signed [15:0] sn;
    logic signed [17:0] ccx;
    logic signed [17:0] ccy;
    logic [15:0] size_x;
    logic [15:0] size_y;
    logic [15:0] cut_x;
    logic [15:0] cut_y;
    logic [15:0] cut_w;
    logic [15:0] cut_h;
    logic [13:0] tex_width;
    logic [13:0] tex_height;
    logic [31:0] color;
  } sqvs_job_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] n;
    logic [DIV_DW-1:0] d;
  } sqvs_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] q;
  } sqvs_div_rsp_t;

  function automatic logic signed [31:0] atan_turn(input logic [3:0] i);
    logic signed [31:0] r;
    case (i)
      4'd0:    r = 32'sd536870912;
      4'd1:    r = 32'sd316933406;
      4'd2:    r = 32'sd167458907;
      4'd3:    r = 32'sd85004756;
      4'd4:    r = 32'sd42667331;
      4'd5:    r = 32'sd21354465;
      4'd6:    r = 32'sd10679838;
      4'd7:    r = 32'sd5340245;
      4'd8:    r = 32'sd2670163;
      4'd9:    r = 32'sd1335086;
      4'd10:   r = 32'sd667544;
      4'd11:   r = 32'sd333772;
      4'd12:   r = 32'sd166886;
      4'd13:   r = 32'sd83443;
      4'd14:   r = 32'sd41722;
      4'd15:   r = 32'sd20861;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat_unit(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd16384) begin
      r = 16'sd16384;
    end else if (v < -17'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_s16(input logic signed [36:0] v);
    logic signed [15:0] r;
    if (v > 37'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -37'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> sv/sqvs_front.sv
module sqvs_front import sqvs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sqvs_in_t  in_data,
  output logic      push,
  output sqvs_job_t push_data,
  input  logic      full
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [1:0]        quad_r;
  sqvs_in_t          item_r;
  logic signed [32:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic              accept;
  logic [31:0]       a_turn;

  assign in_stall = busy_r && !(done_r && !full);
  assign accept   = in_valid && !in_stall;
  assign push     = busy_r && done_r && !full;
  assign a_turn   = {in_data.angle, 16'h0000} + 32'h2000_0000;

  // Four CORDIC micro-rotations per cycle.
  always_comb begin
    logic signed [32:0] xv, yv, xs, ys;
    logic signed [31:0] zv;
    logic [3:0] idx;
    xv = x_r;
    yv = y_r;
    zv = z_r;
    for (int j = 0; j < 4; j++) begin
      idx = {cnt_r, 2'(j)};
      xs = xv >>> idx;
      ys = yv >>> idx;
      if (zv >= 0) begin
        xv = xv - ys;
        yv = yv + xs;
        zv = zv - atan_turn(idx);
      end else begin
        xv = xv + ys;
        yv = yv - xs;
        zv = zv + atan_turn(idx);
      end
    end
    x_nxt = xv;
    y_nxt = yv;
    z_nxt = zv;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b0;
    end else if (busy_r && !done_r) begin
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        done_nxt = 1'b1;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      quad_r <= a_turn[31:30];
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= signed'({2'b00, a_turn[29:0]}) - 32'sh2000_0000;
    end else if (busy_r && !done_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // Round to Q1.14, clamp, then rotate by the quarter turns.
  always_comb begin
    logic signed [15:0] cr, sr;
    cr = sat_unit(17'((x_r + 33'sd32768) >>> 16));
    sr = sat_unit(17'((y_r + 33'sd32768) >>> 16));
    case (quad_r)
      2'd0: begin
        push_data.cs = cr;
        push_data.sn = sr;
      end
      2'd1: begin
        push_data.cs = -sr;
        push_data.sn = cr;
      end
      2'd2: begin
        push_data.cs = -cr;
        push_data.sn = -sr;
      end
      default: begin
        push_data.cs = sr;
        push_data.sn = -cr;
      end
    endcase
    push_data.ccx = {item_r.pos_x[15], item_r.pos_x, 1'b0} + {2'b00, item_r.size_x};
    push_data.ccy = {item_r.pos_y[15], item_r.pos_y, 1'b0} + {2'b00, item_r.size_y};
    push_data.size_x     = item_r.size_x;
    push_data.size_y     = item_r.size_y;
    push_data.cut_x      = item_r.cut_x;
    push_data.cut_y      = item_r.cut_y;
    push_data.cut_w      = item_r.cut_w;
    push_data.cut_h      = item_r.cut_h;
    push_data.tex_width  = item_r.tex_width;
    push_data.tex_height = item_r.tex_height;
    push_data.color      = item_r.color;
  end

endmodule

>>> sv/sqvs_queue.sv
module sqvs_queue import sqvs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sqvs_job_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output sqvs_job_t head
);

  sqvs_job_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/sqvs_div.sv
module sqvs_div import sqvs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  sqvs_div_req_t req,
  output sqvs_div_rsp_t rsp
);

  logic              busy_r, done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] quot_r;
  logic [DIV_DW-1:0] rem_r, d_r;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] diff;
  logic              ge;

  // One restoring step per cycle.
  assign shifted = {rem_r, quot_r[DIV_NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d_r};
  assign ge      = !diff[DIV_DW+1];

  assign rsp.done = done_r;
  assign rsp.q    = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.n;
      rem_r  <= '0;
      d_r    <= req.d;
    end else if (busy_r) begin
      quot_r <= {quot_r[DIV_NW-2:0], ge};
      rem_r  <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
    end
  end

endmodule

>>> sv/sqvs_back.sv
module sqvs_back import sqvs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  sqvs_job_t     job,
  output logic          pop,
  input  logic [13:0]   screen_width,
  input  logic [13:0]   screen_height,
  output sqvs_div_req_t div_req,
  input  sqvs_div_rsp_t div_rsp,
  output logic          out_valid,
  input  logic          out_stall,
  output sqvs_out_t     out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TEX  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIVX = 3'd3;
  localparam logic [2:0] ST_DIVY = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [1:0]         corner_r, corner_nxt;
  logic               launched_r, launched_nxt;
  logic               out_valid_r, out_valid_nxt;
  sqvs_out_t          out_data_r;
  logic [15:0]        u0_r, u1_r, v0_r, v1_r;
  logic signed [34:0] qx_r, qy_r, qx_c, qy_c;
  logic signed [15:0] nx_r, ny_r;

  logic [13:0]        scr_w, scr_h, tex_h;
  logic               in_div;
  logic signed [35:0] n_s, q_s;
  logic [DIV_DW-1:0]  d_u;
  logic [DIV_NW-1:0]  n_mag;
  logic               neg;
  logic [15:0]        tex_q;
  logic               out_free, load_out;

  assign scr_w = (screen_width == 14'd0) ? 14'd1 : screen_width;
  assign scr_h = (screen_height == 14'd0) ? 14'd1 : screen_height;
  assign tex_h = (job.tex_height == 14'd0) ? 14'd1 : job.tex_height;

  assign in_div = (state_r == ST_TEX) || (state_r == ST_DIVX) || (state_r == ST_DIVY);

  // Numerator and divisor for the quotient this state needs.
  always_comb begin
    logic [16:0] s;
    s   = '0;
    n_s = '0;
    d_u = '0;
    case (state_r)
      ST_TEX: begin
        case (sub_r)
          2'd0:    s = {1'b0, job.cut_x};
          2'd1:    s = {1'b0, job.cut_x} + {1'b0, job.cut_w};
          2'd2:    s = {1'b0, job.cut_y};
          default: s = {1'b0, job.cut_y} + {1'b0, job.cut_h};
        endcase
        if (sub_r[1]) begin
          n_s = signed'({8'd0, s, 11'd0} + {22'd0, tex_h});
          d_u = {4'd0, tex_h, 1'b0};
        end else begin
          n_s = signed'({8'd0, s, 11'd0} + {22'd0, job.tex_width});
          d_u = {4'd0, job.tex_width, 1'b0};
        end
      end
      ST_DIVX: begin
        n_s = 36'(qx_r) + signed'({19'd0, scr_w, 3'd0});
        d_u = {1'b0, scr_w, 4'd0};
      end
      ST_DIVY: begin
        n_s = signed'({19'd0, scr_h, 3'd0}) - 36'(qy_r);
        d_u = {1'b0, scr_h, 4'd0};
      end
      default: begin
        n_s = '0;
        d_u = '0;
      end
    endcase
  end

  // Floor division of a signed numerator through the unsigned divider.
  assign neg   = n_s[35];
  assign n_mag = neg ? (DIV_NW'(-n_s) + DIV_NW'(d_u) - DIV_NW'(1)) : DIV_NW'(n_s);
  assign q_s   = neg ? -signed'(div_rsp.q) : signed'(div_rsp.q);
  assign tex_q = (q_s > 36'sd65535) ? 16'hffff : q_s[15:0];

  assign div_req.start = in_div && !launched_r;
  assign div_req.n     = n_mag;
  assign div_req.d     = d_u;

  // Rotated corner position (centre plus rotated offset), in 2^-14 of 1/32 pixel.
  always_comb begin
    logic signed [16:0] dx, dy;
    logic signed [32:0] p_cx, p_sy, p_sx, p_cy;
    logic signed [34:0] cx_t, cy_t;
    dx   = corner_r[0] ? signed'({1'b0, job.size_x}) : -signed'({1'b0, job.size_x});
    dy   = corner_r[1] ? signed'({1'b0, job.size_y}) : -signed'({1'b0, job.size_y});
    p_cx = job.cs * dx;
    p_sy = job.sn * dy;
    p_sx = job.sn * dx;
    p_cy = job.cs * dy;
    cx_t = 35'(job.ccx) <<< 14;
    cy_t = 35'(job.ccy) <<< 14;
    qx_c = cx_t + 35'(p_cx) - 35'(p_sy);
    qy_c = cy_t + 35'(p_sx) + 35'(p_cy);
  end

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == ST_OUT) && out_free;
  assign pop      = load_out && (corner_r == 2'd3);

  always_comb begin
    state_nxt     = state_r;
    sub_nxt       = sub_r;
    corner_nxt    = corner_r;
    launched_nxt  = launched_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (div_req.start) begin
      launched_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          corner_nxt = 2'd0;
          sub_nxt    = 2'd0;
          state_nxt  = (job.tex_width == 14'd0) ? ST_MUL : ST_TEX;
        end
      end
      ST_TEX: begin
        if (launched_r && div_rsp.done) begin
          launched_nxt = 1'b0;
          sub_nxt      = sub_r + 2'd1;
          if (sub_r == 2'd3) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIVX;
      end
      ST_DIVX: begin
        if (launched_r && div_rsp.done) begin
          launched_nxt = 1'b0;
          state_nxt    = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (launched_r && div_rsp.done) begin
          launched_nxt = 1'b0;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          corner_nxt    = corner_r + 2'd1;
          state_nxt     = (corner_r == 2'd3) ? ST_IDLE : ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sub_r       <= 2'd0;
      corner_r    <= 2'd0;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sub_r       <= sub_nxt;
      corner_r    <= corner_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && job_valid && job.tex_width == 14'd0) begin
      u0_r <= 16'd0;
      u1_r <= 16'd16384;
      v0_r <= 16'd0;
      v1_r <= 16'd16384;
    end
    if (state_r == ST_TEX && launched_r && div_rsp.done) begin
      case (sub_r)
        2'd0:    u0_r <= tex_q;
        2'd1:    u1_r <= tex_q;
        2'd2:    v0_r <= tex_q;
        default: v1_r <= tex_q;
      endcase
    end
    if (state_r == ST_MUL) begin
      qx_r <= qx_c;
      qy_r <= qy_c;
    end
    if (state_r == ST_DIVX && launched_r && div_rsp.done) begin
      nx_r <= sat_s16(37'(q_s) - 37'sd16384);
    end
    if (state_r == ST_DIVY && launched_r && div_rsp.done) begin
      ny_r <= sat_s16(37'(q_s) + 37'sd16384);
    end
    if (load_out) begin
      out_data_r.corner       <= corner_r;
      out_data_r.ndc_x        <= nx_r;
      out_data_r.ndc_y        <= ny_r;
      out_data_r.tex_u        <= corner_r[0] ? u1_r : u0_r;
      out_data_r.tex_v        <= corner_r[1] ? v1_r : v0_r;
      out_data_r.vertex_color <= job.color;
      out_data_r.last         <= corner_r == 2'd3;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/sprite_quad_vertex_setup.sv
// Throughput is set by the shared radix-2 divider, 12 quotients per sprite (8 when the
// texture width is zero); the back end starts each quotient once the last is done.
// The front end holds one sprite at a time and takes the next as it pushes the last
// into the two-entry queue, so it stalls while the queue is full.
// Reset: synchronous, active low; clears control state, screen size returns to 1280 x 720.
module sprite_quad_vertex_setup import sqvs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sqvs_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sqvs_out_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // Viewport size registers; writes to unknown indexes are dropped.
  logic [13:0] screen_width_r, screen_height_r;

  // Front end to queue.
  logic          push, full;
  sqvs_job_t     push_data;

  // Queue to back end.
  logic          pop, head_valid;
  sqvs_job_t     head;

  // Back end to divider.
  sqvs_div_req_t div_req;
  sqvs_div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front: transfer a sprite, run sine/cosine, form the centre, hand it to the queue.
  sqvs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // Queue: decouple the front end from the vertex sequencer.
  sqvs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Shared divider for texture and NDC quotients.
  sqvs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Back: per-sprite texture coordinates, then rotate, map and emit four corners.
  sqvs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (head_valid),
    .job           (head),
    .pop           (pop),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

>>> sv/sqvs_checker.sv
`include "sprite_quad_vertex_setup_defines.svh"

module sqvs_checker import sqvs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input sqvs_out_t out_data
);

  `SQVS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `SQVS_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `SQVS_ASSERT_IMP(a_last_corner, out_valid, out_data.last == (out_data.corner == 2'd3))
  `SQVS_ASSERT_NXT(a_corner_order, out_valid && !out_stall,
                   !out_valid || (out_data.corner == $past(out_data.corner) + 2'd1))

endmodule

bind sprite_quad_vertex_setup sqvs_checker u_sqvs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
